### hdl/hbs_pkg.sv
// Shared constants, types and helpers of the height map box smoothing block.
package hbs_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int LIMIT_DIM   = 4096;
	localparam int WIDTH_TOP   = (MAX_WIDTH < LIMIT_DIM) ? MAX_WIDTH : LIMIT_DIM;
	localparam int ROW_ADDR_W  = (WIDTH_TOP > 1) ? $clog2(WIDTH_TOP) : 1;
	localparam int COORD_W     = 12;
	localparam int DIM_W       = 13;
	localparam int IDX_W       = 2;
	localparam int NUM_SLOTS   = 4;

	localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(1);

	localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(512);
	localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(WIDTH_TOP);
	localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(LIMIT_DIM);

	// One accepted sample together with its position flags.
	typedef struct packed {
		logic [COORD_W-1:0]     x;
		logic [COORD_W-1:0]     y;
		logic [SAMPLE_BITS-1:0] val;
		logic [SAMPLE_BITS-1:0] prev;
		logic                   has_left;
		logic                   last_col;
		logic                   has_up;
		logic                   last_row;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0]     x;
		logic [COORD_W-1:0]     y;
		logic [SAMPLE_BITS-1:0] value;
		logic                   frame_last;
	} result_t;

	// Index of the last column or row for a written dimension; zero counts as one, and a value above top counts as top.
	function automatic logic [COORD_W-1:0] last_index(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] top);
		logic [DIM_W-1:0] d;
		begin
			if (v == '0) begin
				d = DIM_W'(1);
			end else if (v > top) begin
				d = top;
			end else begin
				d = v;
			end
			last_index = COORD_W'(d - DIM_W'(1));
		end
	endfunction

endpackage

### hdl/heightmap_box_smooth.sv
// Top level of the streaming 2x2 box smoothing block for height maps.
//
//  channel   direction  handshake                    payload
//  input     in         in_valid / in_stall          sample_value
//  result    out        out_valid / out_stall        out_x, out_y, smoothed_value, frame_last
//  config    in         cfg_wr_en                    cfg_index, cfg_data
//
// A sample is held in one work stage that emits its results, zero to four, one per
// cycle into the output register unless the result side stalls; the next sample
// enters as the stage retires. The line store is read once when a sample enters and
// written at most once, when it retires and has a left neighbour.
// Reset clears counters and control; the line store needs no clearing pass.
// A stall on the result side holds the work stage and, in turn, stalls the input.
module heightmap_box_smooth (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [15:0]                         sample_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [11:0]                         out_x,
	output logic [11:0]                         out_y,
	output logic [15:0]                         smoothed_value,
	output logic                                frame_last,
	input  logic                                cfg_wr_en,
	input  logic [hbs_pkg::IDX_W-1:0]           cfg_index,
	input  logic [hbs_pkg::DIM_W-1:0]           cfg_data
);

	hbs_pkg::item_t                  item;
	hbs_pkg::item_t                  item_s1;
	logic                            valid_s1;
	logic [hbs_pkg::NUM_SLOTS-1:0]   pend_s1;
	logic [hbs_pkg::NUM_SLOTS-1:0]   pend_init;
	logic [hbs_pkg::NUM_SLOTS-1:0]   pick;
	logic [hbs_pkg::NUM_SLOTS-1:0]   pend_rest;
	logic [hbs_pkg::ROW_ADDR_W-1:0]  rd_addr;
	logic [hbs_pkg::SAMPLE_BITS-1:0] rd_data;
	logic [hbs_pkg::SAMPLE_BITS-1:0] last_h_q;
	logic [hbs_pkg::SAMPLE_BITS:0]   sum_h;
	logic [hbs_pkg::SAMPLE_BITS:0]   sum_up;
	logic [hbs_pkg::SAMPLE_BITS:0]   sum_edge;
	logic [hbs_pkg::SAMPLE_BITS-1:0] h_left;
	logic [hbs_pkg::COORD_W-1:0]     x_left;
	logic [hbs_pkg::COORD_W-1:0]     y_up;
	hbs_pkg::result_t                res;
	hbs_pkg::result_t                out_q;
	logic                            out_valid_q;
	logic                            accept;
	logic                            emit_ok;
	logic                            do_emit;
	logic                            retire;

	hbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.sample_value (sample_value),
		.item         (item),
		.rd_addr      (rd_addr)
	);

	hbs_row_mem u_row_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (retire && item_s1.has_left),
		.wr_addr (x_left[hbs_pkg::ROW_ADDR_W-1:0]),
		.wr_data (h_left)
	);

	// Results a sample can complete: above-left, left on the last row,
	// above on the last column, and the sample itself at the frame's corner.
	assign pend_init = {item.last_col & item.last_row, item.last_col & item.has_up,
		item.has_left & item.last_row, item.has_left & item.has_up};

	assign sum_h    = {1'b0, item_s1.prev} + {1'b0, item_s1.val};
	assign h_left   = sum_h[hbs_pkg::SAMPLE_BITS:1];
	assign sum_up   = {1'b0, rd_data} + {1'b0, h_left};
	assign sum_edge = {1'b0, last_h_q} + {1'b0, item_s1.val};
	assign x_left   = item_s1.x - hbs_pkg::COORD_W'(1);
	assign y_up     = item_s1.y - hbs_pkg::COORD_W'(1);

	assign pick      = pend_s1 & (~pend_s1 + hbs_pkg::NUM_SLOTS'(1));
	assign pend_rest = pend_s1 & ~pick;

	always_comb begin
		res.x          = item_s1.x;
		res.y          = item_s1.y;
		res.value      = item_s1.val;
		res.frame_last = 1'b1;
		if (pick[0]) begin
			res.x          = x_left;
			res.y          = y_up;
			res.value      = sum_up[hbs_pkg::SAMPLE_BITS:1];
			res.frame_last = 1'b0;
		end else if (pick[1]) begin
			res.x          = x_left;
			res.value      = h_left;
			res.frame_last = 1'b0;
		end else if (pick[2]) begin
			res.y          = y_up;
			res.value      = sum_edge[hbs_pkg::SAMPLE_BITS:1];
			res.frame_last = 1'b0;
		end
	end

	assign emit_ok  = !out_valid_q || !out_stall;
	assign do_emit  = valid_s1 && (pend_s1 != '0) && emit_ok;
	assign retire   = valid_s1 && ((pend_s1 == '0) || (do_emit && (pend_rest == '0)));
	assign in_stall = valid_s1 && !retire;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_s1  <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			pend_s1  <= pend_init;
		end else if (retire) begin
			valid_s1 <= 1'b0;
			pend_s1  <= '0;
		end else if (do_emit) begin
			pend_s1  <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		// The last column's horizontal value lives here rather than in the line store.
		if (retire && item_s1.last_col) begin
			last_h_q <= item_s1.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_x          = out_q.x;
	assign out_y          = out_q.y;
	assign smoothed_value = out_q.value;
	assign frame_last     = out_q.frame_last;

endmodule

### hdl/hbs_row_mem.sv
// Line store of horizontal results: one write port and one registered read port.
module hbs_row_mem (
	input  logic                                clk,
	input  logic                                rd_en,
	input  logic [hbs_pkg::ROW_ADDR_W-1:0]      rd_addr,
	output logic [hbs_pkg::SAMPLE_BITS-1:0]     rd_data,
	input  logic                                wr_en,
	input  logic [hbs_pkg::ROW_ADDR_W-1:0]      wr_addr,
	input  logic [hbs_pkg::SAMPLE_BITS-1:0]     wr_data
);

	logic [hbs_pkg::SAMPLE_BITS-1:0] mem [hbs_pkg::WIDTH_TOP];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/hbs_ctrl.sv
// Configuration registers, raster position counters and previous-sample register.
module hbs_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [hbs_pkg::IDX_W-1:0]           cfg_index,
	input  logic [hbs_pkg::DIM_W-1:0]           cfg_data,
	input  logic                                accept,
	input  logic [hbs_pkg::SAMPLE_BITS-1:0]     sample_value,
	output hbs_pkg::item_t                      item,
	output logic [hbs_pkg::ROW_ADDR_W-1:0]      rd_addr
);

	logic [hbs_pkg::COORD_W-1:0]     w_last_q;
	logic [hbs_pkg::COORD_W-1:0]     h_last_q;
	logic [hbs_pkg::COORD_W-1:0]     x_q;
	logic [hbs_pkg::COORD_W-1:0]     y_q;
	logic [hbs_pkg::SAMPLE_BITS-1:0] prev_q;
	logic [hbs_pkg::COORD_W-1:0]     x_left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= hbs_pkg::last_index(hbs_pkg::DIM_RESET, hbs_pkg::WIDTH_MAX);
			h_last_q <= hbs_pkg::last_index(hbs_pkg::DIM_RESET, hbs_pkg::HEIGHT_MAX);
			x_q      <= '0;
			y_q      <= '0;
			prev_q   <= '0;
		end else if (cfg_wr_en) begin
			// Any recognised register write restarts the frame.
			unique case (cfg_index)
				hbs_pkg::REG_WIDTH: begin
					w_last_q <= hbs_pkg::last_index(cfg_data, hbs_pkg::WIDTH_MAX);
					x_q      <= '0;
					y_q      <= '0;
					prev_q   <= '0;
				end
				hbs_pkg::REG_HEIGHT: begin
					h_last_q <= hbs_pkg::last_index(cfg_data, hbs_pkg::HEIGHT_MAX);
					x_q      <= '0;
					y_q      <= '0;
					prev_q   <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			prev_q <= sample_value;
			if (x_q == w_last_q) begin
				x_q <= '0;
				if (y_q == h_last_q) begin
					y_q <= '0;
				end else begin
					y_q <= y_q + hbs_pkg::COORD_W'(1);
				end
			end else begin
				x_q <= x_q + hbs_pkg::COORD_W'(1);
			end
		end
	end

	assign x_left  = x_q - hbs_pkg::COORD_W'(1);
	assign rd_addr = x_left[hbs_pkg::ROW_ADDR_W-1:0];

	always_comb begin
		item.x        = x_q;
		item.y        = y_q;
		item.val      = sample_value;
		item.prev     = prev_q;
		item.has_left = (x_q != '0);
		item.last_col = (x_q == w_last_q);
		item.has_up   = (y_q != '0);
		item.last_row = (y_q == h_last_q);
	end

endmodule
